// ===== hw/rtl/hybrid_quicksort_engine_macros.svh =====
`ifndef HYBRID_QUICKSORT_ENGINE_MACROS_SVH
`define HYBRID_QUICKSORT_ENGINE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HQS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define HQS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hqs_pkg.sv =====
`default_nettype none
package hqs_pkg;
   localparam int MAX_ITEMS_DEF = 1024;
   localparam int VALUE_W       = 32;
   localparam int IDX_PORT_W    = 10;
   localparam int COUNT_PORT_W  = 11;
   localparam int CUTOFF_W      = 11;
   localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 11'd10;
   localparam int REQ_DATA_W    = 48;
   localparam int RSP_DATA_W    = 48;
   localparam int RSP_USER_W    = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PARTITION = 2'd0,
      CSR_MEDIAN    = 2'd1,
      CSR_CUTOFF    = 2'd2
   } csr_index_type;
endpackage
`default_nettype wire

// ===== hw/rtl/hybrid_quicksort_engine.sv =====
`default_nettype none
`include "hybrid_quicksort_engine_macros.svh"
// Sorting engine for signed 32-bit values. Load requests (tuser 0) append one value per
// cycle; a load with tlast stores its value and then sorts the store ascending by quicksort
// (Lomuto or Hoare partition, end-element or median-of-three pivot), with ranges whose span
// is below small_cutoff finished by insertion sort, and then returns one completion response.
// A read request (tuser 1) returns the entry at read_index, or flags index_error, by way of
// the registered RAM read and then the response register. While sorting, req_tready stays
// low: every compare or swap step goes through the single read and single write port of the
// value RAM; a sort visits about n*log2(n) elements on typical data and up to n*n/2 on
// adversarial data. No clearing pass runs after reset. The port goes low again after a
// read request until its response has been taken.
module hybrid_quicksort_engine #(
   parameter int MAX_ITEMS = hqs_pkg::MAX_ITEMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] load_value, [41:32] read_index, [47:42] zero
   input  logic [hqs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] entry_value, [42:32] entry_count, [47:43] zero
   output logic [hqs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] sort_done, [1] index_error
   output logic [hqs_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                              csr_we,
   input  logic [hqs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hqs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hqs_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int PW    = IDX_W + 2;
   localparam int CMP_W = (CNT_W > COUNT_PORT_W) ? CNT_W : COUNT_PORT_W;
   localparam int NS    = 31;

   typedef logic signed [PW-1:0] pos_type;

   typedef enum logic [NS-1:0] {
      S_IDLE  = (31'd1 << 0),  S_RDW   = (31'd1 << 1),  S_RESP  = (31'd1 << 2),
      S_INIT  = (31'd1 << 3),  S_POP   = (31'd1 << 4),  S_POPW  = (31'd1 << 5),
      S_INS_I = (31'd1 << 6),  S_INS_K = (31'd1 << 7),  S_INS_J = (31'd1 << 8),
      S_INS_C = (31'd1 << 9),  S_PV    = (31'd1 << 10), S_PVW   = (31'd1 << 11),
      S_MA    = (31'd1 << 12), S_MB    = (31'd1 << 13), S_MC    = (31'd1 << 14),
      S_MD    = (31'd1 << 15), S_ME    = (31'd1 << 16), S_PSET  = (31'd1 << 17),
      S_LJ    = (31'd1 << 18), S_LC    = (31'd1 << 19), S_LS1   = (31'd1 << 20),
      S_LS2   = (31'd1 << 21), S_LF    = (31'd1 << 22), S_LF2   = (31'd1 << 23),
      S_HI    = (31'd1 << 24), S_HIC   = (31'd1 << 25), S_HJ    = (31'd1 << 26),
      S_HJC   = (31'd1 << 27), S_HSW   = (31'd1 << 28), S_PU1   = (31'd1 << 29),
      S_PU2   = (31'd1 << 30)
   } state_type;

   function automatic pos_type to_pos(input logic [IDX_W-1:0] a);
      to_pos = $signed(PW'(a));
   endfunction

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, sp_ff, sp_in;
   logic closed_ff, closed_in;
   logic scheme_ff, median_ff;
   logic [CUTOFF_W-1:0] cutoff_ff;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   pos_type i_ff, i_in, j_ff, j_in, m_ff, m_in, p_ff, p_in;
   logic signed [VALUE_W-1:0] pv_ff, pv_in, key_ff, key_in, va_ff, va_in, vb_ff, vb_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_done_ff, rsp_done_in, rsp_err_ff, rsp_err_in;

   logic v_we, s_we;
   logic [IDX_W-1:0] v_wa, v_ra, s_wa, s_ra;
   logic [VALUE_W-1:0] v_wd, v_rd;
   logic [2*IDX_W-1:0] s_wd, s_rd;
   logic signed [VALUE_W-1:0] rd_s;

   logic req_acc, rsp_acc;
   logic [CNT_W-1:0] count_eff;
   logic [CMP_W-1:0] idx_ext;
   logic [IDX_W-1:0] pop_lo, pop_hi, mid;
   pos_type lo_pos, hi_pos, push_a, push_b;
   logic not_a, not_b;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata = {(RSP_DATA_W - VALUE_W - COUNT_PORT_W)'(0),
                       COUNT_PORT_W'(count_ff), rsp_value_ff};
   assign rsp_tuser = {rsp_err_ff, rsp_done_ff};

   assign rd_s    = $signed(v_rd);
   assign idx_ext = CMP_W'(req_tdata[VALUE_W +: IDX_PORT_W]);
   assign count_eff = closed_ff ? '0 : count_ff;
   assign pop_lo  = s_rd[2*IDX_W-1:IDX_W];
   assign pop_hi  = s_rd[IDX_W-1:0];
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_pos  = to_pos(lo_ff);
   assign hi_pos  = to_pos(hi_ff);
   // Median-of-three: reject a candidate when the two differences have the same sign.
   assign not_a = ((va_ff > vb_ff) && (rd_s < va_ff)) || ((va_ff < vb_ff) && (rd_s > va_ff));
   assign not_b = ((vb_ff > va_ff) && (rd_s < vb_ff)) || ((vb_ff < va_ff) && (rd_s > vb_ff));
   assign push_a = (state_ff == S_PU1) ? lo_pos : p_ff + PW'(1);
   assign push_b = (state_ff == S_PU1) ? (scheme_ff ? p_ff : p_ff - PW'(1)) : hi_pos;

   hqs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_values (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd));

   hqs_ram #(.WIDTH(2*IDX_W), .DEPTH(MAX_ITEMS)) u_stack (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= 1'b0;
         median_ff <= 1'b1;
         cutoff_ff <= CUTOFF_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PARTITION: scheme_ff <= csr_wdata[0];
            CSR_MEDIAN:    median_ff <= csr_wdata[0];
            CSR_CUTOFF:    cutoff_ff <= csr_wdata[CUTOFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         closed_ff <= 1'b0;
         sp_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         closed_ff <= closed_in;
         sp_ff     <= sp_in;
      end
      lo_ff <= lo_in;  hi_ff <= hi_in;
      i_ff  <= i_in;   j_ff  <= j_in;
      m_ff  <= m_in;   p_ff  <= p_in;
      pv_ff <= pv_in;  key_ff <= key_in;
      va_ff <= va_in;  vb_ff <= vb_in;
      rsp_value_ff <= rsp_value_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_comb begin
      state_in = state_ff;   count_in = count_ff;  closed_in = closed_ff;
      sp_in = sp_ff;         lo_in = lo_ff;        hi_in = hi_ff;
      i_in = i_ff;           j_in = j_ff;          m_in = m_ff;
      p_in = p_ff;           pv_in = pv_ff;        key_in = key_ff;
      va_in = va_ff;         vb_in = vb_ff;
      rsp_value_in = rsp_value_ff;
      rsp_done_in = rsp_done_ff;
      rsp_err_in = rsp_err_ff;
      v_we = 1'b0;  v_wa = '0;  v_wd = '0;  v_ra = '0;
      s_we = 1'b0;  s_wa = '0;  s_wd = '0;  s_ra = '0;

      case (state_ff)
         S_IDLE: begin
            v_ra = idx_ext[IDX_W-1:0];
            if (req_acc) begin
               if (req_tuser) begin
                  rsp_done_in = 1'b0;
                  rsp_err_in  = !(idx_ext < CMP_W'(count_ff));
                  state_in    = S_RDW;
               end else begin
                  closed_in = 1'b0;
                  count_in  = count_eff;
                  if (count_eff < CNT_W'(MAX_ITEMS)) begin
                     v_we = 1'b1;
                     v_wa = count_eff[IDX_W-1:0];
                     v_wd = req_tdata[VALUE_W-1:0];
                     count_in = count_eff + CNT_W'(1);
                  end
                  if (req_tlast) begin
                     state_in = S_INIT;
                  end
               end
            end
         end
         S_RDW: begin
            rsp_value_in = rsp_err_ff ? '0 : v_rd;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_acc) begin
               state_in = S_IDLE;
            end
         end
         S_INIT: begin
            sp_in = '0;
            if (count_ff >= CNT_W'(2)) begin
               s_we  = 1'b1;
               s_wa  = '0;
               s_wd  = {IDX_W'(0), IDX_W'(count_ff - CNT_W'(1))};
               sp_in = CNT_W'(1);
            end
            state_in = S_POP;
         end
         S_POP: begin
            s_ra = IDX_W'(sp_ff - CNT_W'(1));
            if (sp_ff == '0) begin
               rsp_value_in = '0;
               rsp_done_in  = 1'b1;
               rsp_err_in   = 1'b0;
               closed_in    = 1'b1;
               state_in     = S_RESP;
            end else begin
               sp_in    = sp_ff - CNT_W'(1);
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            lo_in = pop_lo;
            hi_in = pop_hi;
            if (CMP_W'(pop_hi - pop_lo) < CMP_W'(cutoff_ff)) begin
               i_in = to_pos(pop_lo) + PW'(1);
               state_in = S_INS_I;
            end else if (median_ff) begin
               state_in = S_MA;
            end else begin
               state_in = S_PV;
            end
         end
         // insertion sort over [lo, hi]
         S_INS_I: begin
            v_ra = i_ff[IDX_W-1:0];
            state_in = (i_ff > hi_pos) ? S_POP : S_INS_K;
         end
         S_INS_K: begin
            key_in = rd_s;
            j_in = i_ff - PW'(1);
            state_in = S_INS_J;
         end
         S_INS_J: begin
            v_ra = j_ff[IDX_W-1:0];
            if (j_ff < lo_pos) begin
               v_we = 1'b1;
               v_wa = IDX_W'(j_ff + PW'(1));
               v_wd = key_ff;
               i_in = i_ff + PW'(1);
               state_in = S_INS_I;
            end else begin
               state_in = S_INS_C;
            end
         end
         S_INS_C: begin
            v_we = 1'b1;
            v_wa = IDX_W'(j_ff + PW'(1));
            if (rd_s > key_ff) begin
               v_wd = v_rd;
               j_in = j_ff - PW'(1);
               state_in = S_INS_J;
            end else begin
               v_wd = key_ff;
               i_in = i_ff + PW'(1);
               state_in = S_INS_I;
            end
         end
         // end-element pivot
         S_PV: begin
            v_ra = scheme_ff ? lo_ff : hi_ff;
            state_in = S_PVW;
         end
         S_PVW: begin
            pv_in = rd_s;
            state_in = S_PSET;
         end
         // median of three, then swap it into the pivot slot
         S_MA: begin
            v_ra = lo_ff;
            state_in = S_MB;
         end
         S_MB: begin
            va_in = rd_s;
            v_ra = mid;
            state_in = S_MC;
         end
         S_MC: begin
            vb_in = rd_s;
            v_ra = hi_ff;
            state_in = S_MD;
         end
         S_MD: begin
            if (!not_a) begin
               m_in = lo_pos;     pv_in = va_ff;
            end else if (!not_b) begin
               m_in = to_pos(mid); pv_in = vb_ff;
            end else begin
               m_in = hi_pos;     pv_in = rd_s;
            end
            key_in = scheme_ff ? va_ff : rd_s;
            v_we = 1'b1;
            v_wa = scheme_ff ? lo_ff : hi_ff;
            v_wd = (!not_a) ? va_ff : ((!not_b) ? vb_ff : rd_s);
            state_in = S_ME;
         end
         S_ME: begin
            v_we = 1'b1;
            v_wa = m_ff[IDX_W-1:0];
            v_wd = key_ff;
            state_in = S_PSET;
         end
         S_PSET: begin
            if (scheme_ff) begin
               i_in = lo_pos - PW'(1);
               j_in = hi_pos + PW'(1);
               state_in = S_HI;
            end else begin
               i_in = lo_pos;
               j_in = lo_pos;
               state_in = S_LJ;
            end
         end
         // Lomuto scan
         S_LJ: begin
            if (j_ff < hi_pos) begin
               v_ra = j_ff[IDX_W-1:0];
               state_in = S_LC;
            end else begin
               v_ra = i_ff[IDX_W-1:0];
               state_in = S_LF;
            end
         end
         S_LC: begin
            v_ra = i_ff[IDX_W-1:0];
            if (rd_s < pv_ff) begin
               key_in = rd_s;
               state_in = S_LS1;
            end else begin
               j_in = j_ff + PW'(1);
               state_in = S_LJ;
            end
         end
         S_LS1: begin
            v_we = 1'b1;
            v_wa = j_ff[IDX_W-1:0];
            v_wd = v_rd;
            state_in = S_LS2;
         end
         S_LS2: begin
            v_we = 1'b1;
            v_wa = i_ff[IDX_W-1:0];
            v_wd = key_ff;
            i_in = i_ff + PW'(1);
            j_in = j_ff + PW'(1);
            state_in = S_LJ;
         end
         S_LF: begin
            v_we = 1'b1;
            v_wa = hi_ff;
            v_wd = v_rd;
            state_in = S_LF2;
         end
         S_LF2: begin
            v_we = 1'b1;
            v_wa = i_ff[IDX_W-1:0];
            v_wd = pv_ff;
            p_in = i_ff;
            state_in = S_PU1;
         end
         // Hoare scan: advance i while below pivot, retreat j while above
         S_HI: begin
            v_ra = IDX_W'(i_ff + PW'(1));
            i_in = i_ff + PW'(1);
            state_in = S_HIC;
         end
         S_HIC: begin
            if (rd_s < pv_ff) begin
               v_ra = IDX_W'(i_ff + PW'(1));
               i_in = i_ff + PW'(1);
            end else begin
               va_in = rd_s;
               state_in = S_HJ;
            end
         end
         S_HJ: begin
            v_ra = IDX_W'(j_ff - PW'(1));
            j_in = j_ff - PW'(1);
            state_in = S_HJC;
         end
         S_HJC: begin
            if (rd_s > pv_ff) begin
               v_ra = IDX_W'(j_ff - PW'(1));
               j_in = j_ff - PW'(1);
            end else if (i_ff >= j_ff) begin
               p_in = j_ff;
               state_in = S_PU1;
            end else begin
               v_we = 1'b1;
               v_wa = i_ff[IDX_W-1:0];
               v_wd = v_rd;
               state_in = S_HSW;
            end
         end
         S_HSW: begin
            v_we = 1'b1;
            v_wa = j_ff[IDX_W-1:0];
            v_wd = va_ff;
            state_in = S_HI;
         end
         // push left part, then right part; drop ranges of fewer than two entries and pushes onto a full stack
         S_PU1, S_PU2: begin
            if ((push_a < push_b) && (sp_ff < CNT_W'(MAX_ITEMS))) begin
               s_we  = 1'b1;
               s_wa  = sp_ff[IDX_W-1:0];
               s_wd  = {push_a[IDX_W-1:0], push_b[IDX_W-1:0]};
               sp_in = sp_ff + CNT_W'(1);
            end
            state_in = (state_ff == S_PU1) ? S_PU2 : S_POP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   `HQS_ASSERT_ALWAYS(a_ready_excl, clock, reset, !(req_tready && rsp_tvalid), "ready during response")
   `HQS_ASSERT_NEXT(a_last_sorts, clock, reset, req_acc && !req_tuser && req_tlast, state_ff == S_INIT, "last load did not start sort")
   `HQS_ASSERT_ALWAYS(a_count_max, clock, reset, count_ff <= CNT_W'(MAX_ITEMS), "count beyond capacity")
   `HQS_ASSERT_IMPL(a_done_clean, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tuser[1] && (rsp_tdata[VALUE_W-1:0] == '0), "bad completion response")
endmodule
`default_nettype wire

// ===== hw/rtl/hqs_ram.sv =====
`default_nettype none
module hqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire
